// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned WinWords   = 16;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] HashInit [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       start;
    logic       step;
    logic [5:0] rnd;
    logic       fold;
    logic       init;
  } sha256_ctrl_t;

endpackage

// ===== hdl/sha256_round.sv =====
module sha256_round (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sha256_pkg::sha256_ctrl_t ctrl_i,
  input  logic [2:0]               word_sel_i,
  output logic [31:0]              word_o
);
  import sha256_pkg::*;

  logic [31:0] hash_q [HashWords];
  logic [31:0] v_q    [HashWords];
  logic [31:0] w_q    [WinWords];

  logic [31:0] t1, t2, w_new;
  logic [31:0] sum1, sum0, ch, maj, sig0, sig1;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    sum1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    sum0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + sum1 + ch + RoundK[ctrl_i.rnd] + w_q[0];
    t2    = sum0 + maj;
    sig0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sig1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_new = sig1 + w_q[9] + sig0 + w_q[0];
  end

  assign word_o = hash_q[word_sel_i];

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HashWords; i++) hash_q[i] <= HashInit[i];
    end else if (ctrl_i.init) begin
      for (int i = 0; i < HashWords; i++) hash_q[i] <= HashInit[i];
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < HashWords; i++) hash_q[i] <= hash_q[i] + v_q[i];
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < HashWords; i++) v_q[i] <= hash_q[i];
    end else if (ctrl_i.step) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
    if (ctrl_i.shift) begin
      for (int i = 0; i < WinWords - 1; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[WinWords-1] <= {w_q[WinWords-1][23:0], ctrl_i.data};
    end else if (ctrl_i.step) begin
      for (int i = 0; i < WinWords - 1; i++) w_q[i] <= w_q[i+1];
      w_q[WinWords-1] <= w_new;
    end
  end

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// channel   dir  fields
// s_axis    in   tdata: msg_byte, tuser: byte_valid, tlast: end_of_message
// m_axis    out  tdata: digest_word, word_index, tlast: last_word
//
// a byte that fills the block adds 64 rounds plus a fold on the round unit
// end of message: padding bytes are shifted in, each padded block runs the rounds and a fold,
// then 8 digest transfers, each held until taken
// input is not ready while rounds, fold, padding or digest output are in progress
// reset loads the initial hash values and clears the byte count
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic        m_axis_tlast
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  state_e       state_q, state_d;
  logic [60:0]  count_q, count_d;
  logic [5:0]   fill_q, fill_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic         mark_q, mark_d;
  logic         len_q, len_d;
  logic         pend_q, pend_d;
  sha256_ctrl_t ctrl;
  logic [63:0]  len_bits;
  logic [31:0]  word;

  assign len_bits = {count_q, 3'b000} >> {~fill_q[2:0], 3'b000};

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    fill_d        = fill_q;
    rnd_d         = rnd_q;
    idx_d         = idx_q;
    mark_d        = mark_q;
    len_d         = len_q;
    pend_d        = pend_q;
    ctrl          = '0;
    ctrl.rnd      = rnd_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser[0]) begin
            ctrl.shift = 1'b1;
            ctrl.data  = s_axis_tdata;
            count_d    = count_q + 61'd1;
            fill_d     = fill_q + 6'd1;
          end
          if (s_axis_tuser[0] && fill_q == FillLast) begin
            ctrl.start = 1'b1;
            rnd_d      = '0;
            pend_d     = s_axis_tlast;
            state_d    = ST_ROUND;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        ctrl.step = 1'b1;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == RoundLast) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl.fold = 1'b1;
        if (len_q) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else if (mark_q || pend_q) begin
          pend_d  = 1'b0;
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        ctrl.shift = 1'b1;
        fill_d     = fill_q + 6'd1;
        if (!mark_q) begin
          ctrl.data = PadMark;
          mark_d    = 1'b1;
        end else if (fill_q == LenStart || len_q) begin
          ctrl.data = len_bits[7:0];
          len_d     = 1'b1;
        end else begin
          ctrl.data = '0;
        end
        if (fill_q == FillLast) begin
          ctrl.start = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
        end
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == WordLast) begin
            ctrl.init = 1'b1;
            count_d   = '0;
            mark_d    = 1'b0;
            len_d     = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      fill_q  <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  sha256_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .word_sel_i (idx_q),
    .word_o     (word)
  );

  assign m_axis_tdata = {5'b00000, idx_q, word};
  assign m_axis_tlast = (idx_q == WordLast);

endmodule
